FILE: hdl/ecd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types and codes of the elevator car dispatch unit.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int ECD_FLOORS      = 16;
    localparam int ECD_QUEUE_DEPTH = 4;
    localparam int ECD_FLOOR_W     = 4;
    localparam int ECD_MODE_W      = 3;
    localparam int ECD_ACTION_W    = 3;
    localparam int ECD_SLOTS       = 7;
    localparam int ECD_SLOT_W      = 3;

    // event kinds
    localparam logic [ECD_MODE_W-1:0] MODE_FLOOR       = 3'd0;
    localparam logic [ECD_MODE_W-1:0] MODE_DOOR_OPENED = 3'd1;
    localparam logic [ECD_MODE_W-1:0] MODE_DOOR_CLOSED = 3'd2;
    localparam logic [ECD_MODE_W-1:0] MODE_HALL_CALL   = 3'd3;
    localparam logic [ECD_MODE_W-1:0] MODE_CAR_CALL    = 3'd4;

    // command codes
    localparam logic [ECD_ACTION_W-1:0] ACT_STOP     = 3'd0;
    localparam logic [ECD_ACTION_W-1:0] ACT_OPEN     = 3'd1;
    localparam logic [ECD_ACTION_W-1:0] ACT_CLOSE    = 3'd2;
    localparam logic [ECD_ACTION_W-1:0] ACT_UP       = 3'd3;
    localparam logic [ECD_ACTION_W-1:0] ACT_DOWN     = 3'd4;
    localparam logic [ECD_ACTION_W-1:0] ACT_LAMP_ON  = 3'd5;
    localparam logic [ECD_ACTION_W-1:0] ACT_LAMP_OFF = 3'd6;

    // command slots of one event, in the order they go out
    localparam logic [ECD_SLOT_W-1:0] SLOT_STOP         = 3'd0;
    localparam logic [ECD_SLOT_W-1:0] SLOT_OPEN         = 3'd1;
    localparam logic [ECD_SLOT_W-1:0] SLOT_CLOSE        = 3'd2;
    localparam logic [ECD_SLOT_W-1:0] SLOT_LAMP_OFF_CUR = 3'd3;
    localparam logic [ECD_SLOT_W-1:0] SLOT_LAMP_ON_CALL = 3'd4;
    localparam logic [ECD_SLOT_W-1:0] SLOT_LAMP_OFF_CALL = 3'd5;
    localparam logic [ECD_SLOT_W-1:0] SLOT_MOVE         = 3'd6;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    // all commands caused by one event
    typedef struct packed {
        logic [ECD_SLOTS-1:0]   mask;
        logic                   move_down;
        logic [ECD_FLOOR_W-1:0] cur_floor;
        logic [ECD_FLOOR_W-1:0] call_floor;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle data;
    } t_push;

    typedef struct packed {
        logic    valid;
        t_bundle data;
    } t_head;

endpackage

FILE: hdl/ecd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_front
// Takes events, updates the car state and builds the command bundle.
// ----------------------------------------------------------------------------
module ecd_front import ecd_pkg::*; #(
    parameter int FLOORS = ECD_FLOORS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ev_valid,
    output logic                   o_ev_ready,
    input  logic [ECD_MODE_W-1:0]  i_mode,
    input  logic [ECD_FLOOR_W-1:0] i_floor,
    input  logic                   i_up_dir,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_data,
    input  logic                   i_q_full,
    output t_push                  o_push
);

    localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(FLOORS - 1);

    logic [FLOORS-1:0]      r_pend, n_pend;
    t_dir                   r_dir [FLOORS];
    t_dir                   n_dir [FLOORS];
    t_dir                   r_motion, n_motion;
    logic                   r_door, n_door;
    logic [ECD_FLOOR_W-1:0] r_cur, n_cur;
    logic                   r_lamp_en;

    logic                   accept;
    logic                   fl_ok;
    logic [IDX_W-1:0]       ci;
    logic [IDX_W-1:0]       fi;
    logic [FLOORS-1:0]      cur_oh;
    logic [FLOORS-1:0]      below_mask;
    logic                   only;
    logic                   stop;
    logic                   go_up;
    logic                   go_down;
    t_dir                   motion_mid;
    logic [ECD_SLOTS-1:0]   mask;

    // no event is taken while reset is held
    assign o_ev_ready = i_rst_n && !i_q_full;
    assign accept     = i_ev_valid && o_ev_ready;

    always_comb begin
        fl_ok = (32'(i_floor) < FLOORS);
        n_cur = (i_mode == MODE_FLOOR && fl_ok) ? i_floor : r_cur;
        ci    = IDX_W'(n_cur);
        fi    = IDX_W'(i_floor);
        cur_oh     = FLOORS'(1) << ci;
        below_mask = cur_oh - FLOORS'(1);

        n_pend   = r_pend;
        n_dir    = r_dir;
        n_motion = r_motion;
        n_door   = r_door;
        mask     = '0;

        // stop check on the state before this event
        only = (ci == '0) || (ci == TOP_IDX) || !(|(r_pend & ~cur_oh));
        stop = (r_pend[ci] && r_dir[ci] == r_motion) || only;
        if (stop) begin
            mask[SLOT_STOP]         = 1'b1;
            mask[SLOT_OPEN]         = r_door;
            mask[SLOT_CLOSE]        = r_door;
            mask[SLOT_LAMP_OFF_CUR] = r_lamp_en;
            n_motion  = DIR_NONE;
            n_pend[ci] = 1'b0;
            n_dir[ci]  = DIR_NONE;
            n_door     = !r_door;
        end

        case (i_mode)
            MODE_DOOR_OPENED: begin
                n_door = 1'b0;
            end
            MODE_DOOR_CLOSED: begin
                n_door = 1'b1;
            end
            MODE_HALL_CALL: begin
                if (fl_ok) begin
                    n_pend[fi] = 1'b1;
                    n_dir[fi]  = i_up_dir ? DIR_UP : DIR_DOWN;
                end
            end
            MODE_CAR_CALL: begin
                if (fl_ok) begin
                    mask[SLOT_LAMP_ON_CALL] = r_lamp_en;
                    n_pend[fi] = 1'b1;
                    if (n_cur > i_floor) begin
                        n_dir[fi] = DIR_DOWN;
                    end else if (n_cur < i_floor) begin
                        n_dir[fi] = DIR_UP;
                    end else begin
                        // call at the floor the car stands on
                        mask[SLOT_LAMP_OFF_CALL] = r_lamp_en;
                        n_pend[fi] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        motion_mid = n_motion;
        go_up   = (motion_mid != DIR_DOWN) && (|(n_pend & ~below_mask));
        if (go_up) begin
            n_motion = DIR_UP;
        end
        go_down = (n_motion != DIR_UP) && (|(n_pend & below_mask));
        if (go_down) begin
            n_motion = DIR_DOWN;
        end
        mask[SLOT_MOVE] = go_up || go_down;

        o_push.valid           = accept && (|mask);
        o_push.data.mask       = mask;
        o_push.data.move_down  = go_down;
        o_push.data.cur_floor  = n_cur;
        o_push.data.call_floor = i_floor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_motion  <= DIR_NONE;
            r_door    <= 1'b0;
            r_cur     <= '0;
            r_lamp_en <= 1'b1;
            for (int k = 0; k < FLOORS; k++) begin
                r_dir[k] <= DIR_NONE;
            end
        end else begin
            if (i_cfg_valid) begin
                r_lamp_en <= i_cfg_data;
            end
            if (accept) begin
                r_pend   <= n_pend;
                r_dir    <= n_dir;
                r_motion <= n_motion;
                r_door   <= n_door;
                r_cur    <= n_cur;
            end
        end
    end

endmodule

FILE: hdl/ecd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_queue
// Short first-in first-out queue of command bundles.
// ----------------------------------------------------------------------------
module ecd_queue import ecd_pkg::*; #(
    parameter int DEPTH = ECD_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full      = (r_cnt == FULL_CNT);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.data  = r_mem[r_rd];

    always_comb begin
        do_push = i_push.valid && !o_full;
        do_pop  = i_pop && o_head.valid;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

endmodule

FILE: hdl/ecd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_back
// Sends out the commands of each bundle one word a cycle while i_ready is high.
// ----------------------------------------------------------------------------
module ecd_back import ecd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_head                   i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ECD_ACTION_W-1:0] o_action,
    output logic [ECD_FLOOR_W-1:0]  o_lamp_floor,
    output logic                    o_last
);

    logic                   r_busy, n_busy;
    t_bundle                r_bun, n_bun;
    logic [ECD_SLOT_W-1:0]  sel;
    logic [ECD_SLOTS-1:0]   low_bit;
    logic                   advance;
    logic                   load;

    always_comb begin
        sel = SLOT_STOP;
        for (int k = ECD_SLOTS - 1; k >= 0; k--) begin
            if (r_bun.mask[k]) begin
                sel = ECD_SLOT_W'(k);
            end
        end
        low_bit = r_bun.mask & (~r_bun.mask + ECD_SLOTS'(1));
    end

    always_comb begin
        o_lamp_floor = '0;
        case (sel)
            SLOT_STOP: begin
                o_action = ACT_STOP;
            end
            SLOT_OPEN: begin
                o_action = ACT_OPEN;
            end
            SLOT_CLOSE: begin
                o_action = ACT_CLOSE;
            end
            SLOT_LAMP_OFF_CUR: begin
                o_action     = ACT_LAMP_OFF;
                o_lamp_floor = r_bun.cur_floor;
            end
            SLOT_LAMP_ON_CALL: begin
                o_action     = ACT_LAMP_ON;
                o_lamp_floor = r_bun.call_floor;
            end
            SLOT_LAMP_OFF_CALL: begin
                o_action     = ACT_LAMP_OFF;
                o_lamp_floor = r_bun.call_floor;
            end
            SLOT_MOVE: begin
                o_action = r_bun.move_down ? ACT_DOWN : ACT_UP;
            end
            default: begin
                o_action = ACT_STOP;
            end
        endcase
    end

    assign o_valid = r_busy;
    assign o_last  = (r_bun.mask & ~low_bit) == '0;
    assign advance = r_busy && i_ready;
    // next bundle comes in as the final word of this one leaves
    assign load    = !r_busy || (advance && o_last);
    assign o_pop   = load && i_head.valid;

    always_comb begin
        n_busy = r_busy;
        n_bun  = r_bun;
        if (load) begin
            n_busy = i_head.valid;
            n_bun  = i_head.data;
        end else if (advance) begin
            n_bun.mask = r_bun.mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bun <= n_bun;
    end

endmodule

FILE: hdl/elevator_car_dispatch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_dispatch_unit
// Dispatch controller for one elevator car: events in, car commands out.
// ----------------------------------------------------------------------------
//  channel    dir  word
//  s_axis     in   event: floor, up_dir in tdata; mode in tuser
//  m_axis     out  command: lamp_floor in tdata; action in tuser; tlast on final
//  cfg        in   lamp_enable
//
//  an event is taken whenever the bundle queue has room and reset is released;
//  its state update is complete at the edge that takes it. the back end sends
//  one command word a cycle while m_axis is ready; an event yields 0..7 words.
//  a stall on m_axis fills the queue before s_axis is held off.
//  synchronous reset clears the car state at once; no clearing pass.
// ----------------------------------------------------------------------------
module elevator_car_dispatch_unit import ecd_pkg::*; #(
    parameter int FLOORS      = ECD_FLOORS,
    parameter int QUEUE_DEPTH = ECD_QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [7:0]              i_s_axis_tdata,   // floor[3:0], up_dir[4], zero[7:5]
    input  logic [ECD_MODE_W-1:0]   i_s_axis_tuser,   // mode[2:0]
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [7:0]              o_m_axis_tdata,   // lamp_floor[3:0], zero[7:4]
    output logic [ECD_ACTION_W-1:0] o_m_axis_tuser,   // action[2:0]
    output logic                    o_m_axis_tlast,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_data        // lamp_enable
);

    t_push                   push;
    t_head                   head;
    logic                    q_full;
    logic                    pop;
    logic [ECD_FLOOR_W-1:0]  lamp_floor;

    assign o_cfg_ready = i_rst_n;

    ecd_front #(
        .FLOORS (FLOORS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (i_s_axis_tvalid),
        .o_ev_ready  (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_floor     (i_s_axis_tdata[3:0]),
        .i_up_dir    (i_s_axis_tdata[4]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push)
    );

    ecd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    ecd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_action     (o_m_axis_tuser),
        .o_lamp_floor (lamp_floor),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, lamp_floor};

endmodule
